// ===== src/dls_pkg.sv =====
package dls_pkg;

  // Layer sizes.
  localparam int IN_MAX        = 64;
  localparam int OUT_MAX       = 16;
  localparam int SIG_ROM_DEPTH = 4096;

  // Derived sizes.
  localparam int W_DEPTH  = IN_MAX * OUT_MAX;
  localparam int W_AW     = $clog2(W_DEPTH);
  localparam int SIG_AW   = $clog2(SIG_ROM_DEPTH);
  localparam int SIG_HALF = SIG_ROM_DEPTH / 2;
  localparam int OUT_IW   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int POS_W    = $clog2(IN_MAX + 1);

  // Field and datapath widths.
  localparam int CFG_W = 5;
  localparam int VAL_W = 16;
  localparam int ACC_W = 40;
  localparam int MUL_W = 33;
  localparam int PRD_W = 2 * MUL_W;

  // Table build divider: 16-bit quotient, 43-bit divisor, 58-bit dividend.
  localparam int QW      = 16;
  localparam int DIV_DW  = 43;
  localparam int DIV_NW  = DIV_DW + QW - 1;
  localparam int DCNT_W  = $clog2(QW + 1);

  // Operation codes of an input item.
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_ACT    = 1'b1;

  // exp(-1/256) in Q2.62 from a truncated Taylor series.
  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TAY_T1  = Q62_ONE / 64'd256;
  localparam logic [63:0] TAY_T2  = TAY_T1 / 64'd512;
  localparam logic [63:0] TAY_T3  = TAY_T2 / 64'd768;
  localparam logic [63:0] TAY_T4  = TAY_T3 / 64'd1024;
  localparam logic [63:0] TAY_T5  = TAY_T4 / 64'd1280;
  localparam logic [63:0] TAY_T6  = TAY_T5 / 64'd1536;
  localparam logic [63:0] TAY_T7  = TAY_T6 / 64'd1792;
  localparam logic [63:0] TAY_T8  = TAY_T7 / 64'd2048;
  localparam logic [63:0] TAY_T9  = TAY_T8 / 64'd2304;
  localparam logic [63:0] TAY_T10 = TAY_T9 / 64'd2560;
  localparam logic [63:0] TAY_T11 = TAY_T10 / 64'd2816;
  localparam logic [63:0] TAY_T12 = TAY_T11 / 64'd3072;
  localparam logic [63:0] TAY_T13 = TAY_T12 / 64'd3328;
  localparam logic [63:0] TAY_T14 = TAY_T13 / 64'd3584;
  localparam logic [63:0] TAY_T15 = TAY_T14 / 64'd3840;
  localparam logic [63:0] EXP_STEP = Q62_ONE - TAY_T1 + TAY_T2 - TAY_T3 + TAY_T4
                                     - TAY_T5 + TAY_T6 - TAY_T7 + TAY_T8 - TAY_T9
                                     + TAY_T10 - TAY_T11 + TAY_T12 - TAY_T13
                                     + TAY_T14 - TAY_T15;

  typedef struct packed {
    logic               operation;
    logic [5:0]         weight_row;
    logic [3:0]         weight_column;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  neuron;
    logic [15:0] activation;
    logic        final_res;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MAC    = 9'b000000010,
    ST_OUT_RD = 9'b000000100,
    ST_OUT_LD = 9'b000001000,
    ST_B_POS  = 9'b000010000,
    ST_B_PWT  = 9'b000100000,
    ST_B_NEG  = 9'b001000000,
    ST_B_NWT  = 9'b010000000,
    ST_B_MUL  = 9'b100000000
  } state_t;

endpackage

// ===== src/dls_mul.sv =====
module dls_mul (
  input  logic                                clk,
  input  logic signed [dls_pkg::MUL_W-1:0]    a,
  input  logic signed [dls_pkg::MUL_W-1:0]    b,
  output logic signed [dls_pkg::PRD_W-1:0]    p
);

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== src/dls_div.sv =====
module dls_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dls_pkg::div_req_t req,
  output dls_pkg::div_rsp_t rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [dls_pkg::DCNT_W-1:0]  cnt_r;
  logic [dls_pkg::DIV_NW-1:0]  rem_r;
  logic [dls_pkg::DIV_NW-1:0]  ds_r;
  logic [dls_pkg::QW-1:0]      q_r;
  logic                        ge;

  assign ge = (rem_r >= ds_r);

  // Control: one quotient bit per cycle, a done pulse after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= dls_pkg::DCNT_W'(dls_pkg::QW);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == dls_pkg::DCNT_W'(1));
        if (cnt_r == dls_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Restoring division: the divisor starts at its top position and walks down.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      ds_r  <= {req.den, {(dls_pkg::QW - 1){1'b0}}};
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - ds_r;
      end
      q_r  <= {q_r[dls_pkg::QW-2:0], ge};
      ds_r <= ds_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== src/dense_layer_sigmoid_unit.sv =====
// Weight write: accepted without a stall; in_stall stays low.
// Activation: the weight read, the shared multiplier and the accumulator add are
// pipelined, one neuron issued per cycle.
// Final activation: per neuron, a sigmoid table read, then an output load that waits on out_stall.
// After reset the sigmoid table is built by the shared multiplier and a serial divider
// over 2049 steps with in_stall high.
module dense_layer_sigmoid_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dls_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dls_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dls_pkg::CFG_W-1:0]   cfg_data
);

  dls_pkg::state_t state_r, state_nxt;

  logic [dls_pkg::CFG_W-1:0]   out_count_r;
  logic [dls_pkg::CFG_W-1:0]   n_eff;
  logic [dls_pkg::POS_W-1:0]   pos_r;
  logic signed [dls_pkg::VAL_W-1:0] val_r;
  logic                        last_r;
  logic                        mac_en_r;

  // Accumulate pipeline.
  logic [dls_pkg::CFG_W-1:0]   rd_c_r;
  logic                        v1_r, v2_r;
  logic [dls_pkg::OUT_IW-1:0]  c1_r, c2_r;
  logic signed [dls_pkg::ACC_W-1:0] acc_r [dls_pkg::OUT_MAX];
  logic signed [dls_pkg::ACC_W-1:0] prod40;

  // Output phase.
  logic [dls_pkg::CFG_W-1:0]   oc_r;
  logic                        oc_final;
  logic                        out_free;
  logic                        out_valid_r;
  dls_pkg::out_item_t          out_data_r;
  logic signed [dls_pkg::ACC_W-1:0] acc_sel;
  logic signed [31:0]          acc_y;
  logic signed [31:0]          y_cl;
  logic signed [31:0]          y_off;

  localparam logic signed [31:0] Y_MAX  = 32'(dls_pkg::SIG_HALF - 1);
  localparam logic signed [31:0] Y_MIN  = 32'(-dls_pkg::SIG_HALF);
  localparam logic signed [31:0] Y_HALF = 32'(dls_pkg::SIG_HALF);

  // Table build.
  logic [dls_pkg::SIG_AW-1:0]  k_r;
  logic [63:0]                 e_r;
  logic [127:0]                pacc_r;
  logic [127:0]                pp_shift;
  logic [127:0]                pacc_sum;
  logic [2:0]                  mc_r;
  logic [63:0]                 prod64;
  logic [40:0]                 e40;
  logic [41:0]                 dsum;
  logic [55:0]                 n_neg;
  logic [dls_pkg::DIV_NW-1:0]  num_pos;
  logic [dls_pkg::DIV_NW-1:0]  num_neg;
  dls_pkg::div_req_t           div_req;
  dls_pkg::div_rsp_t           div_rsp;

  // Shared multiplier.
  logic signed [dls_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [dls_pkg::PRD_W-1:0] mul_p;

  // Memories.
  logic [15:0]                 wmem [dls_pkg::W_DEPTH];
  logic [15:0]                 wdata_r;
  logic                        w_we;
  logic [dls_pkg::W_AW-1:0]    w_waddr;
  logic [dls_pkg::W_AW-1:0]    w_raddr;
  logic [15:0]                 smem [dls_pkg::SIG_ROM_DEPTH];
  logic [15:0]                 sdata_r;
  logic                        s_we;
  logic [dls_pkg::SIG_AW-1:0]  s_waddr;
  logic [dls_pkg::SIG_AW-1:0]  s_raddr;

  logic in_acc;
  logic issue;
  logic mac_done;

  dls_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  dls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Handshake and sequencing conditions.
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != dls_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign n_eff     = (out_count_r > dls_pkg::CFG_W'(dls_pkg::OUT_MAX)) ?
                     dls_pkg::CFG_W'(dls_pkg::OUT_MAX) : out_count_r;
  assign issue     = (state_r == dls_pkg::ST_MAC) && mac_en_r && (rd_c_r < n_eff);
  assign mac_done  = (state_r == dls_pkg::ST_MAC) && !issue && !v1_r && !v2_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign oc_final  = (dls_pkg::CFG_W'(oc_r + 1'b1) == n_eff);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign prod40    = mul_p[dls_pkg::ACC_W-1:0];
  assign prod64    = mul_p[63:0];

  // Weight store addressing.
  assign w_we    = in_acc && (in_data.operation == dls_pkg::OP_WEIGHT) &&
                   (int'(in_data.weight_row) < dls_pkg::IN_MAX) &&
                   (int'(in_data.weight_column) < dls_pkg::OUT_MAX);
  assign w_waddr = dls_pkg::W_AW'(int'(in_data.weight_row) * dls_pkg::OUT_MAX +
                                  int'(in_data.weight_column));
  assign w_raddr = dls_pkg::W_AW'(int'(pos_r) * dls_pkg::OUT_MAX + int'(rd_c_r));

  // Sum to table index: drop the fraction bits, clamp, then offset to unsigned.
  assign acc_sel = acc_r[oc_r[dls_pkg::OUT_IW-1:0]];
  assign acc_y   = acc_sel[dls_pkg::ACC_W-1:8];
  assign y_cl    = (acc_y > Y_MAX) ? Y_MAX : ((acc_y < Y_MIN) ? Y_MIN : acc_y);
  assign y_off   = y_cl + Y_HALF;
  assign s_raddr = y_off[dls_pkg::SIG_AW-1:0];

  // Table entry operands: e40 = e >> 22, d = 2^40 + e40, dividend 2n + d, divisor 2d.
  assign e40     = e_r[62:22];
  assign dsum    = {2'b01, 40'b0} + {1'b0, e40};
  assign n_neg   = 56'({e40, 16'b0} - {16'b0, e40});
  assign num_pos = dls_pkg::DIV_NW'({16'hffff, 40'b0, 1'b0}) + dls_pkg::DIV_NW'(dsum);
  assign num_neg = dls_pkg::DIV_NW'({n_neg, 1'b0}) + dls_pkg::DIV_NW'(dsum);

  assign div_req.start = ((state_r == dls_pkg::ST_B_POS) &&
                          (k_r != dls_pkg::SIG_AW'(dls_pkg::SIG_HALF))) ||
                         ((state_r == dls_pkg::ST_B_NEG) && (k_r != '0));
  assign div_req.num   = (state_r == dls_pkg::ST_B_POS) ? num_pos : num_neg;
  assign div_req.den   = {dsum, 1'b0};

  assign s_we    = div_rsp.done && ((state_r == dls_pkg::ST_B_PWT) ||
                                    (state_r == dls_pkg::ST_B_NWT));
  assign s_waddr = (state_r == dls_pkg::ST_B_PWT) ?
                   dls_pkg::SIG_AW'(dls_pkg::SIG_HALF) + k_r :
                   dls_pkg::SIG_AW'(dls_pkg::SIG_HALF) - k_r;

  // Multiplier operands: Q2.62 partial products during the build, else one MAC.
  always_comb begin
    if (state_r == dls_pkg::ST_B_MUL) begin
      case (mc_r)
        3'd1: begin
          mul_a = {1'b0, e_r[31:0]};
          mul_b = {1'b0, dls_pkg::EXP_STEP[63:32]};
        end
        3'd2: begin
          mul_a = {1'b0, e_r[63:32]};
          mul_b = {1'b0, dls_pkg::EXP_STEP[31:0]};
        end
        3'd3: begin
          mul_a = {1'b0, e_r[63:32]};
          mul_b = {1'b0, dls_pkg::EXP_STEP[63:32]};
        end
        default: begin
          mul_a = {1'b0, e_r[31:0]};
          mul_b = {1'b0, dls_pkg::EXP_STEP[31:0]};
        end
      endcase
    end else begin
      mul_a = dls_pkg::MUL_W'(val_r);
      mul_b = dls_pkg::MUL_W'($signed(wdata_r));
    end
  end

  // Partial product placement; the product arrives in the cycle after its issue.
  always_comb begin
    case (mc_r) inside
      3'd2, 3'd3: pp_shift = {64'b0, prod64} << 32;
      3'd4:       pp_shift = {64'b0, prod64} << 64;
      default:    pp_shift = {64'b0, prod64};
    endcase
    pacc_sum = ((mc_r == 3'd1) ? 128'b0 : pacc_r) + pp_shift;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dls_pkg::ST_IDLE: begin
        if (in_acc && (in_data.operation == dls_pkg::OP_ACT)) begin
          state_nxt = dls_pkg::ST_MAC;
        end
      end
      dls_pkg::ST_MAC: begin
        if (mac_done) begin
          state_nxt = (last_r && (n_eff != '0)) ? dls_pkg::ST_OUT_RD : dls_pkg::ST_IDLE;
        end
      end
      dls_pkg::ST_OUT_RD: begin
        state_nxt = dls_pkg::ST_OUT_LD;
      end
      dls_pkg::ST_OUT_LD: begin
        if (out_free) begin
          state_nxt = oc_final ? dls_pkg::ST_IDLE : dls_pkg::ST_OUT_RD;
        end
      end
      dls_pkg::ST_B_POS: begin
        state_nxt = (k_r == dls_pkg::SIG_AW'(dls_pkg::SIG_HALF)) ?
                    dls_pkg::ST_B_NEG : dls_pkg::ST_B_PWT;
      end
      dls_pkg::ST_B_PWT: begin
        if (div_rsp.done) begin
          state_nxt = dls_pkg::ST_B_NEG;
        end
      end
      dls_pkg::ST_B_NEG: begin
        state_nxt = (k_r == '0) ? dls_pkg::ST_B_MUL : dls_pkg::ST_B_NWT;
      end
      dls_pkg::ST_B_NWT: begin
        if (div_rsp.done) begin
          state_nxt = dls_pkg::ST_B_MUL;
        end
      end
      dls_pkg::ST_B_MUL: begin
        if (k_r == dls_pkg::SIG_AW'(dls_pkg::SIG_HALF)) begin
          state_nxt = dls_pkg::ST_IDLE;
        end else if (mc_r == 3'd4) begin
          state_nxt = dls_pkg::ST_B_POS;
        end
      end
      default: state_nxt = dls_pkg::ST_IDLE;
    endcase
  end

  // Control and accumulator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dls_pkg::ST_B_POS;
      out_count_r <= dls_pkg::CFG_W'(16);
      pos_r       <= '0;
      last_r      <= 1'b0;
      mac_en_r    <= 1'b0;
      rd_c_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      oc_r        <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      e_r         <= dls_pkg::Q62_ONE;
      mc_r        <= '0;
      for (int i = 0; i < dls_pkg::OUT_MAX; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        out_count_r <= cfg_data;
      end

      // Take an activation item.
      if (in_acc && (in_data.operation == dls_pkg::OP_ACT)) begin
        last_r   <= in_data.last;
        mac_en_r <= (int'(pos_r) < dls_pkg::IN_MAX);
        rd_c_r   <= '0;
      end

      // Issue one neuron per cycle; the accumulate follows through the v1_r and v2_r stages.
      v1_r <= issue;
      v2_r <= v1_r;
      if (issue) begin
        rd_c_r <= rd_c_r + 1'b1;
      end
      if (v2_r) begin
        acc_r[c2_r] <= acc_r[c2_r] + prod40;
      end

      // End of an activation item.
      if (mac_done) begin
        oc_r <= '0;
        if (last_r && (n_eff == '0)) begin
          pos_r <= '0;
          for (int i = 0; i < dls_pkg::OUT_MAX; i++) begin
            acc_r[i] <= '0;
          end
        end else if (mac_en_r) begin
          pos_r <= pos_r + 1'b1;
        end
      end

      // Output register: one result per neuron.
      if ((state_r == dls_pkg::ST_OUT_LD) && out_free) begin
        out_valid_r <= 1'b1;
        oc_r        <= oc_r + 1'b1;
        if (oc_final) begin
          pos_r <= '0;
          for (int i = 0; i < dls_pkg::OUT_MAX; i++) begin
            acc_r[i] <= '0;
          end
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // Table build: next power of exp(-1/256) after both entries of a step.
      if ((state_r == dls_pkg::ST_B_MUL) &&
          (k_r != dls_pkg::SIG_AW'(dls_pkg::SIG_HALF))) begin
        if (mc_r == 3'd4) begin
          mc_r <= '0;
          e_r  <= pacc_sum[125:62];
          k_r  <= k_r + 1'b1;
        end else begin
          mc_r <= mc_r + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.operation == dls_pkg::OP_ACT)) begin
      val_r <= in_data.value;
    end
    c1_r <= rd_c_r[dls_pkg::OUT_IW-1:0];
    c2_r <= c1_r;
    if ((state_r == dls_pkg::ST_B_MUL) && (mc_r != 3'd0)) begin
      pacc_r <= pacc_sum;
    end
    if ((state_r == dls_pkg::ST_OUT_LD) && out_free) begin
      out_data_r.neuron     <= 4'(oc_r);
      out_data_r.activation <= sdata_r;
      out_data_r.final_res  <= oc_final;
    end
  end

  // Weight store.
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= in_data.value;
    end
    wdata_r <= wmem[w_raddr];
  end

  // Sigmoid table.
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= div_rsp.quot;
    end
    sdata_r <= smem[s_raddr];
  end

endmodule

// ===== src/dls_checker.sv =====
module dls_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dls_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dls_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset starts the table build: no input taken, no result shown.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not busy after reset");

  // After a weight write the input is free again in the next cycle.
  a_weight_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == dls_pkg::OP_WEIGHT) |=> !in_stall)
    else $error("weight write held the input");

  // No result can appear in the cycle right after an item is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind dense_layer_sigmoid_unit dls_checker u_dls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/tb_dense_layer_sigmoid_unit.sv =====
module tb_dense_layer_sigmoid_unit;

  localparam int ITEM_TARGET = 370;
  localparam int CALM_TAIL   = 50;
  localparam int IDLE_LIMIT  = 400000;
  localparam int SETTLE_CYC  = 40;
  localparam int DRAIN_CYC   = 80;
  localparam int TBL_HALF    = dls_pkg::SIG_ROM_DEPTH / 2;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dls_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  dls_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [dls_pkg::CFG_W-1:0] cfg_data;

  // Predictor state: sigmoid table, weights, which of them hold data, sums, position, neuron count and due results.
  logic [15:0]        sigmoid_tbl [dls_pkg::SIG_ROM_DEPTH];
  logic signed [15:0] weight_mem [dls_pkg::IN_MAX * dls_pkg::OUT_MAX];
  bit                 weight_known [dls_pkg::IN_MAX * dls_pkg::OUT_MAX];
  logic [39:0]        acc_q16 [dls_pkg::OUT_MAX];
  int                 act_position;
  logic [dls_pkg::CFG_W-1:0] neuron_cfg;
  dls_pkg::out_item_t neuron_results_due [$];

  int  errors;
  int  items_sent;
  int  vectors_done;
  int  results_seen;
  int  cfg_writes;
  bit  calm;
  bit  gaps_on;

  dense_layer_sigmoid_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One table entry: 65535 / (1 + e) or 65535 * e / (1 + e), rounded half up.
  function automatic logic [15:0] sigmoid_point(input logic [63:0] e, input bit positive);
    logic [63:0] e40;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    e40 = e >> 22;
    den = (64'd1 << 40) + e40;
    num = positive ? (64'd65535 << 40) : 64'd65535 * e40;
    q   = (64'd2 * num + den) / (64'd2 * den);
    return q[15:0];
  endfunction

  function automatic int neurons_in_use();
    return (neuron_cfg > dls_pkg::OUT_MAX) ? dls_pkg::OUT_MAX : int'(neuron_cfg);
  endfunction

  // Applies one accepted item to the layer state and queues the neuron results it causes.
  function automatic void layer_step(input dls_pkg::in_item_t item);
    int                 n;
    int                 idx;
    logic signed [31:0] prod;
    logic signed [31:0] y;
    dls_pkg::out_item_t res;
    n = neurons_in_use();
    if (item.operation == dls_pkg::OP_WEIGHT) begin
      if (item.weight_row < dls_pkg::IN_MAX && item.weight_column < dls_pkg::OUT_MAX) begin
        idx = item.weight_row * dls_pkg::OUT_MAX + item.weight_column;
        weight_mem[idx]   = item.value;
        weight_known[idx] = 1'b1;
      end
      return;
    end
    // Multiply-accumulate until the position saturates.
    if (act_position < dls_pkg::IN_MAX) begin
      for (int c = 0; c < n; c++) begin
        prod = item.value * weight_mem[act_position * dls_pkg::OUT_MAX + c];
        acc_q16[c] = acc_q16[c] + {{8{prod[31]}}, prod};
      end
      act_position++;
    end
    // On the last element, squash every sum and clear.
    if (item.last) begin
      for (int c = 0; c < n; c++) begin
        y = $signed(acc_q16[c][39:8]);
        if (y > TBL_HALF - 1)
          idx = dls_pkg::SIG_ROM_DEPTH - 1;
        else if (y < -TBL_HALF)
          idx = 0;
        else
          idx = y + TBL_HALF;
        res.neuron     = c[3:0];
        res.activation = sigmoid_tbl[idx];
        res.final_res  = (c == n - 1);
        neuron_results_due.push_back(res);
      end
      for (int c = 0; c < dls_pkg::OUT_MAX; c++) acc_q16[c] = '0;
      act_position = 0;
      vectors_done++;
    end
  endfunction

  // Mostly values near the sigmoid's useful range, sometimes extremes or anything.
  function automatic logic [15:0] pick_value(input int span);
    int v;
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: begin
        v = $signed($urandom_range(0, 2 * span)) - span;
        return 16'(v);
      end
    endcase
  endfunction

  // Sends one item and updates the predictor when it is taken.
  task automatic send_item(input dls_pkg::in_item_t item);
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    layer_step(item);
    items_sent++;
  endtask

  task automatic send_weight(input int row, input int col, input logic [15:0] w);
    dls_pkg::in_item_t item;
    item.operation     = dls_pkg::OP_WEIGHT;
    item.weight_row    = row[5:0];
    item.weight_column = col[3:0];
    item.value         = w;
    item.last          = 1'($urandom_range(0, 1));
    send_item(item);
  endtask

  task automatic send_activation(input logic [15:0] a, input bit last);
    dls_pkg::in_item_t item;
    item.operation     = dls_pkg::OP_ACT;
    item.weight_row    = 6'($urandom);
    item.weight_column = 4'($urandom);
    item.value         = a;
    item.last          = last;
    send_item(item);
  endtask

  // Holds off the sender until all results are in and the block has gone quiet.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (neuron_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_neuron_count(input logic [dls_pkg::CFG_W-1:0] count);
    settle_block();
    cfg_data  <= count;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    neuron_cfg = count;
    cfg_writes++;
  endtask

  // Makes sure every weight that a vector of this length will read holds data.
  task automatic ensure_weights(input int len, input int span);
    int rows;
    int cols;
    rows = (len < dls_pkg::IN_MAX) ? len : dls_pkg::IN_MAX;
    cols = neurons_in_use();
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (!weight_known[r * dls_pkg::OUT_MAX + c]) send_weight(r, c, pick_value(span));
  endtask

  // Directed: out_count after reset is 16; row 0 carries extreme and spread weights.
  task automatic test_default_count();
    logic [15:0] row0 [16];
    row0 = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h0100, 16'hff00,
             16'h0200, 16'hfe00, 16'h0400, 16'hfc00, 16'h0064, 16'hff9c, 16'h07ff,
             16'hf800, 16'h012c};
    for (int c = 0; c < dls_pkg::OUT_MAX; c++) send_weight(0, c, row0[c]);
    send_activation(16'h0100, 1'b1);
  endtask

  // Directed: one neuron, extreme activations.
  task automatic test_single_neuron();
    set_neuron_count(5'd1);
    send_weight(1, 0, 16'h0003);
    send_activation(16'h7fff, 1'b0);
    send_activation(16'h8000, 1'b1);
  endtask

  // Directed: zero neurons gives no results but still ends the vector.
  task automatic test_zero_neurons();
    set_neuron_count(5'd0);
    send_activation(16'h1234, 1'b0);
    send_activation(16'hedcb, 1'b1);
  endtask

  // Directed: counts above sixteen behave as sixteen.
  task automatic test_count_above_max();
    set_neuron_count(5'd31);
    send_activation(16'hff80, 1'b1);
  endtask

  // Directed: last on a weight write is ignored; highest row and column.
  task automatic test_weight_write_last();
    dls_pkg::in_item_t item;
    item.operation     = dls_pkg::OP_WEIGHT;
    item.weight_row    = 6'd63;
    item.weight_column = 4'd15;
    item.value         = 16'h8000;
    item.last          = 1'b1;
    send_item(item);
    item.weight_row    = 6'd0;
    item.weight_column = 4'd15;
    item.value         = 16'h7fff;
    send_item(item);
  endtask

  // Elements past IN_MAX are dropped; the last mark on one still ends the vector.
  task automatic test_long_vector();
    int v;
    set_neuron_count(5'd1);
    for (int r = 0; r < dls_pkg::IN_MAX; r++) begin
      v = $signed($urandom_range(0, 128)) - 64;
      send_weight(r, 0, 16'(v));
    end
    for (int i = 0; i < dls_pkg::IN_MAX + 6; i++) begin
      v = $signed($urandom_range(0, 128)) - 64;
      send_activation((i < dls_pkg::IN_MAX) ? 16'(v) : pick_value(300),
                      i == dls_pkg::IN_MAX + 5);
    end
  endtask

  // Random layers: a neuron count per phase, then a few vectors with weight updates.
  task automatic test_random_layers();
    logic [dls_pkg::CFG_W-1:0] count;
    int                        len;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: count = 5'd0;
        1: count = 5'($urandom_range(17, 31));
        2: count = 5'd16;
        3: count = 5'd1;
        default: count = 5'($urandom_range(1, 16));
      endcase
      set_neuron_count(count);
      repeat ($urandom_range(2, 5)) begin
        if (neurons_in_use() <= 4 && $urandom_range(0, 5) == 0)
          len = $urandom_range(9, 20);
        else
          len = $urandom_range(1, 6);
        ensure_weights(len, 300);
        repeat ($urandom_range(0, 3))
          send_weight($urandom_range(0, 63), $urandom_range(0, 15), pick_value(300));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0)
            send_weight($urandom_range(0, 63), $urandom_range(0, 15), pick_value(300));
          send_activation(pick_value(300), i == len - 1);
        end
      end
      calm = (items_sent >= ITEM_TARGET - CALM_TAIL);
    end
  endtask

  // Result checking against the oldest expected neuron result.
  always @(posedge clk) begin : result_check
    dls_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (neuron_results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got neuron %0d activation %h final %b",
                 $time, out_data.neuron, out_data.activation, out_data.final_res);
        errors++;
      end else begin
        want = neuron_results_due.pop_front();
        if (out_data.neuron !== want.neuron) begin
          $display("%0t: neuron index: expected %0d, got %0d",
                   $time, want.neuron, out_data.neuron);
          errors++;
        end
        if (out_data.activation !== want.activation) begin
          $display("%0t: activation of neuron %0d: expected %h, got %h",
                   $time, want.neuron, want.activation, out_data.activation);
          errors++;
        end
        if (out_data.final_res !== want.final_res) begin
          $display("%0t: final flag of neuron %0d: expected %b, got %b",
                   $time, want.neuron, want.final_res, out_data.final_res);
          errors++;
        end
      end
    end
  end

  // Receiver stalls in random bursts, with quiet stretches.
  initial begin : result_stalls
    bit stall_on;
    stall_on = 1'b1;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("dense_layer_sigmoid_unit verification failed");
    $finish;
  end

  // Main sequence.
  initial begin : main_flow
    logic [63:0]  step;
    logic [63:0]  term;
    logic [63:0]  e;
    logic [127:0] wide;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    errors       = 0;
    items_sent   = 0;
    vectors_done = 0;
    results_seen = 0;
    cfg_writes   = 0;
    calm         = 1'b0;
    gaps_on      = 1'b1;

    // Sigmoid table: exp(-1/256) by Taylor series in Q2.62, powers by truncating multiplies.
    step = 64'h4000_0000_0000_0000;
    term = step;
    e    = step;
    for (int k = 1; k < 16; k++) begin
      term = term / (64'd256 * k);
      if (k % 2 == 1)
        step = step - term;
      else
        step = step + term;
    end
    for (int k = 0; k <= TBL_HALF; k++) begin
      if (k < TBL_HALF) sigmoid_tbl[TBL_HALF + k] = sigmoid_point(e, 1'b1);
      if (k >= 1) sigmoid_tbl[TBL_HALF - k] = sigmoid_point(e, 1'b0);
      wide = {64'd0, e} * {64'd0, step};
      e = wide[125:62];
    end

    // Layer state after reset.
    for (int i = 0; i < dls_pkg::IN_MAX * dls_pkg::OUT_MAX; i++) begin
      weight_mem[i]   = '0;
      weight_known[i] = 1'b0;
    end
    for (int c = 0; c < dls_pkg::OUT_MAX; c++) acc_q16[c] = '0;
    act_position = 0;
    neuron_cfg   = 5'd16;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_default_count();
    test_single_neuron();
    test_zero_neurons();
    test_count_above_max();
    test_weight_write_last();
    test_long_vector();
    test_random_layers();

    // Drain the remaining results, then give the block time to misbehave.
    in_valid <= 1'b0;
    while (neuron_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d items forming %0d vectors over %0d neuron-count settings.",
             items_sent, vectors_done, cfg_writes);
    $display("Checked %0d neuron results; %0d mismatches.", results_seen, errors);
    if (errors == 0)
      $display("dense_layer_sigmoid_unit verification clean");
    else
      $display("dense_layer_sigmoid_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dls_pkg.sv
src/dls_mul.sv
src/dls_div.sv
src/dense_layer_sigmoid_unit.sv
src/dls_checker.sv
tb/sv/tb_dense_layer_sigmoid_unit.sv
